>>> hw/rtl/signed_long_divider_top_assert.svh
// Assertion macros for the signed long divider top level.
`ifndef SIGNED_LONG_DIVIDER_TOP_ASSERT_SVH
`define SIGNED_LONG_DIVIDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("divider assertion failed");

// Next-cycle implication, disabled during reset.
`define SLD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("divider assertion failed");

`endif

>>> hw/rtl/sld_pkg.sv
// Shared types and constants of the signed long divider.
package sld_pkg;

	localparam int QUOT_W    = 64;
	localparam int REM_OUT_W = 32;
	localparam int CNT_W     = 6;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic div_zero;
	} sts_t;

endpackage

>>> hw/rtl/signed_long_divider_top.sv
// Top level of the signed 64-by-32 long divider.
//
// Input channel: in_valid/in_stall carry one word (dividend, divisor).
// A word is taken when in_valid is high and in_stall is low. in_stall is
// high while the divider works on a word, so one word is in flight at a time.
// Output channel: out_valid/out_stall carry quotient, remainder and
// divide_by_zero; taken when out_valid is high and out_stall is low.
// Quotient truncates toward zero and wraps on overflow; the remainder has
// the sign of the dividend. A zero divisor (low DIVISOR_WIDTH bits) gives
// divide_by_zero with zero results.
// Sequence: load on the accepting edge, 64 non-restoring steps of the shared
// add/subtract unit, then a sign fix-up state that writes the output register;
// a zero divisor skips the steps and goes straight to the fix-up state.
// A new word is taken only after the last one has left the fix-up state.
// The output register parts the two channels: a new word is taken while
// a result still waits. If the receiver stalls, the next result holds in
// the fix-up cycle until the output register frees.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops
// out_valid; no result is pending afterward.
module signed_long_divider_top #(
	parameter int DIVISOR_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sld_pkg::QUOT_W-1:0]    dividend,
	input  logic [sld_pkg::REM_OUT_W-1:0] divisor,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sld_pkg::QUOT_W-1:0]    quotient,
	output logic [sld_pkg::REM_OUT_W-1:0] remainder,
	output logic                          divide_by_zero
);

	`include "signed_long_divider_top_assert.svh"

	sld_pkg::cmd_t cmd;
	sld_pkg::sts_t sts;

	// sequencer: owns the handshakes and the step counter
	sld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: operand magnitudes, quotient/remainder registers, output word
	sld_dp #(
		.DIVISOR_WIDTH (DIVISOR_WIDTH)
	) u_dp (
		.clk            (clk),
		.dividend       (dividend),
		.divisor        (divisor),
		.cmd            (cmd),
		.sts            (sts),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

	// an accepted word keeps the input side closed while it is worked on
	`SLD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// a divide-by-zero result carries zero quotient and remainder
	`SLD_ASSERT_NOW(a_dz_zero, out_valid && divide_by_zero, quotient == '0 && remainder == '0)
	// the output register is only loaded while busy, never on an accept edge
	`SLD_ASSERT_NOW(a_no_load_on_accept, in_valid && !in_stall, !cmd.finish)

endmodule

>>> hw/rtl/sld_ctrl.sv
// Sequencer of the signed long divider: load, quotient bit steps, finish.
module sld_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  sld_pkg::sts_t sts,
	output sld_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	localparam logic [sld_pkg::CNT_W-1:0] CNT_LAST = sld_pkg::CNT_W'(sld_pkg::QUOT_W - 1);

	state_t                    state_q;
	logic [sld_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.step   = (state_q == S_RUN);
	assign cmd.finish = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						// zero divisor skips the bit steps
						state_q <= sts.div_zero ? S_FIN : S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/sld_dp.sv
// Datapath of the signed long divider: magnitudes, non-restoring steps, sign fix-up.
module sld_dp #(
	parameter int DIVISOR_WIDTH = 32
) (
	input  logic                                clk,
	input  logic [sld_pkg::QUOT_W-1:0]          dividend,
	input  logic [sld_pkg::REM_OUT_W-1:0]       divisor,
	input  sld_pkg::cmd_t                       cmd,
	output sld_pkg::sts_t                       sts,
	output logic [sld_pkg::QUOT_W-1:0]          quotient,
	output logic [sld_pkg::REM_OUT_W-1:0]       remainder,
	output logic                                divide_by_zero
);

	localparam int W  = DIVISOR_WIDTH;
	localparam int RW = DIVISOR_WIDTH + 2;

	logic [W-1:0]                 dsr_in;
	logic [W-1:0]                 dsr_q;
	logic [sld_pkg::QUOT_W-1:0]   quo_q;
	logic [RW-1:0]                rem_q;
	logic                         neg_quo_q;
	logic                         neg_rem_q;
	logic                         dz_q;
	logic [RW-1:0]                dext;
	logic [RW-1:0]                shifted;
	logic [RW-1:0]                rem_nxt;
	logic [RW-1:0]                rem_fix;
	logic [W-1:0]                 rem_mag;
	logic signed [W-1:0]          rem_sgn;
	logic [sld_pkg::QUOT_W-1:0]   quo_sgn;
	logic [sld_pkg::QUOT_W-1:0]   quotient_q;
	logic [sld_pkg::REM_OUT_W-1:0] remainder_q;
	logic                         dz_out_q;

	assign dsr_in       = divisor[W-1:0];
	assign sts.div_zero = (dsr_in == '0);

	assign dext    = {2'b00, dsr_q};
	assign shifted = {rem_q[RW-2:0], quo_q[sld_pkg::QUOT_W-1]};
	// add back when the partial remainder is negative, else subtract
	assign rem_nxt = rem_q[RW-1] ? (shifted + dext) : (shifted - dext);

	// final remainder correction, then signs
	assign rem_fix = rem_q[RW-1] ? (rem_q + dext) : rem_q;
	assign rem_mag = rem_fix[W-1:0];
	assign rem_sgn = neg_rem_q ? (W'(0) - rem_mag) : rem_mag;
	assign quo_sgn = neg_quo_q ? (sld_pkg::QUOT_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dsr_q     <= dsr_in[W-1] ? (W'(0) - dsr_in) : dsr_in;
			quo_q     <= dividend[sld_pkg::QUOT_W-1] ? (sld_pkg::QUOT_W'(0) - dividend)
			                                         : dividend;
			rem_q     <= '0;
			neg_quo_q <= dividend[sld_pkg::QUOT_W-1] ^ dsr_in[W-1];
			neg_rem_q <= dividend[sld_pkg::QUOT_W-1];
			dz_q      <= sts.div_zero;
		end else if (cmd.step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[sld_pkg::QUOT_W-2:0], ~rem_nxt[RW-1]};
		end
		if (cmd.finish) begin
			dz_out_q <= dz_q;
			if (dz_q) begin
				quotient_q  <= '0;
				remainder_q <= '0;
			end else begin
				quotient_q  <= quo_sgn;
				remainder_q <= sld_pkg::REM_OUT_W'(rem_sgn);
			end
		end
	end

	assign quotient       = quotient_q;
	assign remainder      = remainder_q;
	assign divide_by_zero = dz_out_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the signed 64-by-32 divider: directed and random words, checked in order.
module tb_top;

	// Divisor width under test; the predictor and the DUT share it.
	localparam int DIV_W        = 32;
	localparam int RAND_WORDS   = 1525;
	localparam int HOLD_CYCLES  = 800;   // long receiver hold-off
	localparam int HOLD_AT      = 300;   // words accepted before the hold-off starts
	localparam int DRAIN_CYCLES = 80;    // drain wait after the last expected result
	localparam int CYCLE_LIMIT  = 2000000;

	// One expected result, with the operands kept for the mismatch report.
	typedef struct {
		logic [sld_pkg::QUOT_W-1:0]    a;
		logic [sld_pkg::REM_OUT_W-1:0] d;
		logic [sld_pkg::QUOT_W-1:0]    q;
		logic [sld_pkg::REM_OUT_W-1:0] r;
		logic                          z;
	} quot_entry_t;

	// Holds the quotients still owed by the divider and checks each one that comes out.
	class quot_ledger;
		quot_entry_t owed[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Low DIV_W bits read as a signed DIV_W-bit value.
		function logic [63:0] sext_div(input logic [63:0] v);
			logic [63:0] m;
			logic [63:0] s;
			m = (64'd1 << DIV_W) - 64'd1;
			s = 64'd1 << (DIV_W - 1);
			return ((v & m) ^ s) - s;
		endfunction

		// Signed division on magnitudes, truncated toward zero, wrapping on overflow.
		function quot_entry_t divide_signed(input logic [63:0] a, input logic [31:0] d);
			quot_entry_t e;
			logic [63:0] b;
			logic [63:0] mag_a;
			logic [63:0] mag_b;
			logic [63:0] q;
			e.a = a;
			e.d = d;
			b = sext_div({32'd0, d});
			if (b == 64'd0) begin
				e.q = '0;
				e.r = '0;
				e.z = 1'b1;
				return e;
			end
			mag_a = a[63] ? 64'd0 - a : a;
			mag_b = b[63] ? 64'd0 - b : b;
			q = mag_a / mag_b;
			if (a[63] != b[63])
				q = 64'd0 - q;
			e.q = q;
			e.r = sld_pkg::REM_OUT_W'(sext_div(a - q * b));
			e.z = 1'b0;
			return e;
		endfunction

		function void note_operands(input logic [63:0] a, input logic [31:0] d);
			owed.push_back(divide_signed(a, d));
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void check_result(input logic [63:0] q, input logic [31:0] r, input logic z);
			quot_entry_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: quotient %h remainder %h dbz %b", q, r, z);
				return;
			end
			e = owed.pop_front();
			if (q !== e.q || r !== e.r || z !== e.z) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch %h / %h: quotient exp %h got %h, ",
						"remainder exp %h got %h, dbz exp %b got %b"},
						e.a, e.d, e.q, q, e.r, r, e.z, z);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [sld_pkg::QUOT_W-1:0]    dividend;
	logic [sld_pkg::REM_OUT_W-1:0] divisor;
	logic                          out_valid;
	logic                          out_stall;
	logic [sld_pkg::QUOT_W-1:0]    quotient;
	logic [sld_pkg::REM_OUT_W-1:0] remainder;
	logic                          divide_by_zero;

	quot_ledger ledger = new();
	int         words_in = 0;
	logic       hold_off;    // forces out_stall high for the long hold-off
	logic       calm;        // stretch with no idling on either side

	// Directed words: extremes, signs, overflow, zero divisors.
	logic [63:0] dir_a [0:24] = '{
		64'd0, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
		64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7,
		64'hFFFF_FFFF_FFFF_FFF9, 64'd7, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
		64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'd1234567,
		64'hFFFF_FFFF_8000_0000
	};
	logic [31:0] dir_d [0:24] = '{
		32'd1, 32'd1, 32'd1, 32'd1,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'd1, 32'hFFFF_FFFF, 32'd2,
		32'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'd0,
		32'd0, 32'd0, 32'd0,
		32'h7FFF_FFFF, 32'h8000_0000, 32'd2, 32'hFFFF_FFFF,
		32'h8000_0000
	};

	// Corner pools for the random part.
	logic [63:0] corner_a [0:5] = '{
		64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0,
		64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h4000_0000_0000_0000
	};
	logic [31:0] corner_d [0:5] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2
	};

	signed_long_divider_top #(
		.DIVISOR_WIDTH(DIV_W)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.dividend      (dividend),
		.divisor       (divisor),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.quotient      (quotient),
		.remainder     (remainder),
		.divide_by_zero(divide_by_zero)
	);

	always #1 clk = ~clk;

	// Idle length: mostly short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Offer one word and hold it until the divider takes it. in_valid is only
	// lowered when a gap follows, so back-to-back words keep it high.
	task automatic send_word(input logic [63:0] a, input logic [31:0] d);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		dividend <= a;
		divisor  <= d;
		// in_stall read here is its value just before the edge
		do @(posedge clk); while (in_stall);
		ledger.note_operands(a, d);
		words_in++;
	endtask

	// Random word drawn from a mix of shapes: full range, small operands,
	// corners, zero divisors, exact multiples and scaled magnitudes.
	task automatic send_random_word();
		logic [63:0] a;
		logic [31:0] d;
		logic [63:0] qs;
		logic [63:0] ds;
		int          roll;
		roll = $urandom_range(0, 99);
		a = rand64();
		d = $urandom();
		if (roll < 30) begin
			// full range as drawn
		end else if (roll < 50) begin
			if ($urandom_range(0, 1))
				a = {{32{a[31]}}, a[31:0]};
			else
				a = {{48{a[15]}}, a[15:0]};
		end else if (roll < 65) begin
			d = $urandom_range(1, 16);
			if ($urandom_range(0, 1))
				d = 32'd0 - d;
		end else if (roll < 75) begin
			a = corner_a[$urandom_range(0, 5)];
			d = corner_d[$urandom_range(0, 5)];
		end else if (roll < 80) begin
			d = '0;
		end else if (roll < 90) begin
			// exact multiple, sometimes one off, so the remainder hits zero
			if (d == 32'd0)
				d = 32'd3;
			qs = {{32{a[31]}}, a[31:0]};
			ds = {{32{d[31]}}, d};
			a = qs * ds;
			case ($urandom_range(0, 2))
				0: a = a - 64'd1;
				2: a = a + 64'd1;
				default: ;
			endcase
		end else begin
			a = a >> $urandom_range(0, 63);
			if ($urandom_range(0, 1))
				a = 64'd0 - a;
			d = d >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				d = 32'd0 - d;
		end
		send_word(a, d);
	endtask

	// Receiver: alternating ready and stall runs, overridden by the hold-off.
	initial begin : stall_drive
		int run;
		bit stalling;
		run = 0;
		stalling = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			while (run == 0) begin
				stalling = !stalling;
				run = stalling ? pick_gap() : $urandom_range(1, 12);
			end
			run--;
			out_stall <= hold_off || (stalling && !calm);
		end
	end

	// Long hold-off once traffic is flowing; the sender keeps offering words
	// so the divider fills and holds in_stall high.
	initial begin : hold_drive
		hold_off <= 1'b0;
		wait (words_in >= HOLD_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Every word taken on the output side goes to the ledger.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_result(quotient, remainder, divide_by_zero);
	end

	// Watchdog: a hung divider ends the run here.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main
		in_valid <= 1'b0;
		dividend <= '0;
		divisor  <= '0;
		calm     <= 1'b0;
		arst_n   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 25; i++)
			send_word(dir_a[i], dir_d[i]);

		// A stretch in the middle runs with no idling on either side.
		for (int i = 0; i < RAND_WORDS; i++) begin
			calm <= (i >= 600 && i < 750);
			send_random_word();
		end
		calm <= 1'b0;

		// last word was taken at this edge; stop offering right away
		in_valid <= 1'b0;
		while (ledger.pending() > 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
